// ===== hw/rtl/ptst_pkg.sv =====
`default_nettype none

package ptst_pkg;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    localparam logic [1:0] KIND_REGISTERED = 2'd0;
    localparam logic [1:0] KIND_FULL       = 2'd1;
    localparam logic [1:0] KIND_FIRED      = 2'd2;
    localparam logic [1:0] KIND_QUIET      = 2'd3;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        opcode;
        logic [15:0] elapsed_ms;
        logic [15:0] period_ms;
        logic [15:0] start_count;
        logic [7:0]  handler_tag;
    } req_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] slot_index;
        logic [7:0] fired_tag;
        logic       last;
    } rsp_word_t;

    // one memory entry per slot
    typedef struct packed {
        logic [15:0] period;
        logic [31:0] count;
        logic [7:0]  tag;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptst_slot_mem.sv =====
`default_nettype none

module ptst_slot_mem
    import ptst_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic        clk,
    input  wire logic        rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output slot_entry_t      rd_data,
    input  wire logic        wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire slot_entry_t wr_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ptst_slot_alu.sv =====
`default_nettype none

module ptst_slot_alu
    import ptst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  wire slot_entry_t entry,
    input  wire logic [15:0] elapsed_ms,
    output logic             fire,
    output slot_entry_t      updated
);

    logic [32:0] raw_sum;
    logic [31:0] sum_next;
    logic [31:0] sum_reg;
    logic [15:0] period_reg;
    logic [7:0]  tag_reg;

    // saturating accumulate, registered ahead of the compare
    assign raw_sum  = {1'b0, entry.count} + {17'd0, elapsed_ms};
    assign sum_next = raw_sum[32] ? COUNT_MAX : raw_sum[31:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg    <= sum_next;
            period_reg <= entry.period;
            tag_reg    <= entry.tag;
        end
    end

    assign fire = (sum_reg >= {16'd0, period_reg});

    always_comb
    begin
        updated.period = period_reg;
        updated.tag    = tag_reg;
        updated.count  = fire ? (sum_reg - {16'd0, period_reg}) : sum_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_timer_slot_table.sv =====
`default_nettype none

// channel | dir | handshake          | word
// req     | in  | req_valid/req_stall | req_word_t: opcode, elapsed, period, start, tag
// rsp     | out | rsp_valid/rsp_stall | rsp_word_t: kind, slot_index, fired_tag, last
//
// Register item: ST_REG loads the result into the output register when it is free.
// Tick item: ST_RD/ST_SUM/ST_UPD per used slot (read, accumulate, compare/write back),
//   then ST_DONE; a new request is taken only once back in ST_IDLE.
// A fired word is held back until the next fire or the tick's end so the final one can carry last.
// Reset empties the table by clearing the fill count; no clearing pass.
// A stalled output blocks the scan only when a second word is ready to go.

module periodic_timer_slot_table
    import ptst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire req_word_t req,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    output rsp_word_t  rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_REG  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    req_word_t        item_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_valid_reg, pend_valid_next;
    rsp_word_t        pend_reg, pend_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_word_t        rsp_reg, rsp_next;

    logic             out_free;
    logic             accept;
    logic             emit;
    rsp_word_t        emit_word;
    logic             mem_rd_en;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_entry_t      mem_wr_data;
    slot_entry_t      mem_rd_data;
    logic             alu_fire;
    slot_entry_t      alu_updated;
    logic [15:0]      start_clamped;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign start_clamped = (item_reg.start_count > item_reg.period_ms)
                         ? item_reg.period_ms : item_reg.start_count;

    ptst_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    ptst_slot_alu u_alu (
        .clk        (clk),
        .load       (state_reg == ST_SUM),
        .entry      (mem_rd_data),
        .elapsed_ms (item_reg.elapsed_ms),
        .fire       (alu_fire),
        .updated    (alu_updated)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        emit_word       = pend_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg[IDX_W-1:0];
        mem_wr_data     = alu_updated;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    if (req.opcode == OP_REGISTER)
                    begin
                        state_next = ST_REG;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_REG:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (fill_reg == FULL_CNT)
                    begin
                        emit_word = '{kind: KIND_FULL, slot_index: '0,
                                      fired_tag: '0, last: 1'b1};
                    end
                    else
                    begin
                        emit_word = '{kind: KIND_REGISTERED,
                                      slot_index: 6'(fill_reg),
                                      fired_tag: item_reg.handler_tag,
                                      last: 1'b1};
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = fill_reg[IDX_W-1:0];
                        mem_wr_data = '{period: item_reg.period_ms,
                                        count: {16'd0, start_clamped},
                                        tag: item_reg.handler_tag};
                        fill_next   = fill_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // a new fire pushes out the held word; wait if output is busy
                if (!(alu_fire && pend_valid_reg && !out_free))
                begin
                    mem_wr_en = 1'b1;
                    if (alu_fire)
                    begin
                        emit            = pend_valid_reg;
                        emit_word       = pend_reg;
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: KIND_FIRED,
                                            slot_index: 6'(idx_reg[IDX_W-1:0]),
                                            fired_tag: alu_updated.tag,
                                            last: 1'b0};
                    end
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == fill_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_word      = pend_reg;
                        emit_word.last = 1'b1;
                    end
                    else
                    begin
                        emit_word = '{kind: KIND_QUIET, slot_index: '0,
                                      fired_tag: '0, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_word;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_SUM || state_reg == ST_UPD)
        |-> idx_reg < fill_reg)
        else $error("scan index past used slots");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_REG) |-> !pend_valid_reg)
        else $error("held fired word outside a tick");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> rsp_valid_reg && rsp_reg.last)
        else $error("end of tick without a last word");

endmodule

`default_nettype wire
